// ===== rtl/core/dns_query_packet_builder_macros.svh =====
// Assertion macros for the DNS query builder.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef DNS_QUERY_PACKET_BUILDER_MACROS_SVH
`define DNS_QUERY_PACKET_BUILDER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define DQB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DQB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DQB_ASSERT_NOW(lbl, ante, cons, msg)
`define DQB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/dqb_pkg.sv =====
package dqb_pkg;

	localparam int LEN_W     = 6;
	localparam int IDX_W     = 6;
	localparam int CFG_IDX_W = 8;

	localparam logic [7:0] SEPARATOR = 8'd46;

	localparam logic [IDX_W-1:0] HDR_LAST = 6'd11;
	localparam logic [IDX_W-1:0] TRL_LAST = 6'd4;

	localparam logic [15:0] RST_QUERY_ID    = 16'd111;
	localparam logic [15:0] RST_HEADER_FLAGS = 16'h0100;
	localparam logic [15:0] RST_QUERY_TYPE  = 16'd15;
	localparam logic [15:0] RST_QUERY_CLASS = 16'd1;

	localparam logic [1:0] COUNT_ONE = 2'd1;
	localparam logic [1:0] COUNT_TWO = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUERY_ID     = 8'd0,
		CFG_HEADER_FLAGS = 8'd1,
		CFG_QUERY_TYPE   = 8'd2,
		CFG_QUERY_CLASS  = 8'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_LEN,
		ST_CHARS,
		ST_EMPTY,
		ST_TRL
	} state_t;

	typedef enum logic [2:0] {
		SRC_HDR,
		SRC_LEN,
		SRC_CHAR,
		SRC_ZERO,
		SRC_TRL
	} src_t;

	// One message byte requested from the datapath.
	typedef struct packed {
		logic             valid;
		src_t             src;
		logic [IDX_W-1:0] idx;
		logic [LEN_W-1:0] len;
		logic             last;
		logic             msg_end;
		logic             ovf;
	} byte_cmd_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} store_wr_t;

	typedef struct packed {
		logic adv;
	} dp_status_t;

endpackage

// ===== rtl/core/dqb_ctrl.sv =====
module dqb_ctrl
	import dqb_pkg::*;
#(
	parameter int MAX_LABEL = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       name_valid,
	output logic       name_stall,
	input  logic [7:0] name_char,
	input  logic       final_char,
	input  dp_status_t status,
	output byte_cmd_t  cmd,
	output store_wr_t  wr
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             start_q, start_d;
	logic             ovf_q, ovf_d;
	logic             sep_q, sep_d;
	logic             final_q, final_d;

	logic   accept;
	logic   is_sep;
	logic   room;
	logic   chars_done;
	state_t after_label;

	assign accept     = name_valid && (state_q == ST_IDLE);
	assign is_sep     = (name_char == SEPARATOR);
	assign room       = (len_q < LEN_W'(MAX_LABEL));
	assign chars_done = (idx_q == IDX_W'(len_q - LEN_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			len_q   <= '0;
			start_q <= 1'b1;
			ovf_q   <= 1'b0;
			sep_q   <= 1'b0;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			len_q   <= len_d;
			start_q <= start_d;
			ovf_q   <= ovf_d;
			sep_q   <= sep_d;
			final_q <= final_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		len_d       = len_q;
		start_d     = start_q;
		ovf_d       = ovf_q;
		sep_d       = sep_q;
		final_d     = final_q;
		cmd         = '0;
		cmd.src     = SRC_ZERO;
		cmd.len     = len_q;
		cmd.ovf     = ovf_q;
		wr          = '0;
		name_stall  = (state_q != ST_IDLE);

		if (sep_q && final_q) begin
			after_label = ST_EMPTY;
		end else if (final_q) begin
			after_label = ST_TRL;
		end else begin
			after_label = ST_IDLE;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					sep_d   = is_sep;
					final_d = final_char;
					start_d = 1'b0;
					idx_d   = '0;
					if (!is_sep) begin
						if (room) begin
							wr.en   = 1'b1;
							wr.addr = IDX_W'(len_q);
							len_d   = len_q + LEN_W'(1);
						end else begin
							ovf_d = 1'b1;
						end
					end
					if (start_q) begin
						state_d = ST_HDR;
					end else if (is_sep || final_char) begin
						state_d = ST_LEN;
					end
				end
			end
			ST_HDR: begin
				cmd.valid = 1'b1;
				cmd.src   = SRC_HDR;
				cmd.idx   = idx_q;
				cmd.last  = (idx_q == HDR_LAST) && !(sep_q || final_q);
				if (status.adv) begin
					if (idx_q == HDR_LAST) begin
						idx_d   = '0;
						state_d = (sep_q || final_q) ? ST_LEN : ST_IDLE;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			ST_LEN: begin
				cmd.valid = 1'b1;
				cmd.src   = SRC_LEN;
				cmd.last  = (len_q == '0) && !final_q;
				if (status.adv) begin
					idx_d   = '0;
					state_d = (len_q == '0) ? after_label : ST_CHARS;
				end
			end
			ST_CHARS: begin
				cmd.valid = 1'b1;
				cmd.src   = SRC_CHAR;
				cmd.idx   = idx_q;
				cmd.last  = chars_done && !final_q;
				if (status.adv) begin
					if (chars_done) begin
						idx_d   = '0;
						len_d   = '0;
						state_d = after_label;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			ST_EMPTY: begin
				cmd.valid = 1'b1;
				cmd.src   = SRC_ZERO;
				if (status.adv) begin
					idx_d   = '0;
					state_d = ST_TRL;
				end
			end
			ST_TRL: begin
				cmd.valid   = 1'b1;
				cmd.src     = SRC_TRL;
				cmd.idx     = idx_q;
				cmd.last    = (idx_q == TRL_LAST);
				cmd.msg_end = (idx_q == TRL_LAST);
				if (status.adv) begin
					if (idx_q == TRL_LAST) begin
						// message done: rearm for the next header
						idx_d   = '0;
						len_d   = '0;
						start_d = 1'b1;
						ovf_d   = 1'b0;
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/dqb_datapath.sv =====
module dqb_datapath
	import dqb_pkg::*;
#(
	parameter int MAX_LABEL = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic [7:0]           name_char,
	input  byte_cmd_t            cmd,
	input  store_wr_t            wr,
	output dp_status_t           status,
	output logic                 msg_valid,
	input  logic                 msg_stall,
	output logic [7:0]           byte_first,
	output logic [7:0]           byte_second,
	output logic [1:0]           byte_count,
	output logic                 run_end,
	output logic                 message_end,
	output logic                 label_overflow
);

	localparam int ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

	logic [15:0] query_id_q, header_flags_q, query_type_q, query_class_q;

	logic [7:0] store_mem [MAX_LABEL];

	logic             v_s1;
	src_t             src_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [LEN_W-1:0] len_s1;
	logic             last_s1, end_s1, ovf_s1;
	logic [7:0]       char_s1;

	logic [7:0] hdr_byte, trl_byte, byte_s1;
	logic       have_q;
	logic [7:0] first_q;
	logic       out_v_q;
	logic [7:0] byte_first_q, byte_second_q;
	logic [1:0] byte_count_q;
	logic       run_end_q, message_end_q, overflow_q;
	logic       adv;
	logic       hold_first;

	assign cfg_ready  = 1'b1;
	assign adv        = !out_v_q || !msg_stall;
	assign status.adv = adv;
	assign hold_first = !have_q && !last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_id_q     <= RST_QUERY_ID;
			header_flags_q <= RST_HEADER_FLAGS;
			query_type_q   <= RST_QUERY_TYPE;
			query_class_q  <= RST_QUERY_CLASS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_QUERY_ID:     query_id_q     <= cfg_data;
				CFG_HEADER_FLAGS: header_flags_q <= cfg_data;
				CFG_QUERY_TYPE:   query_type_q   <= cfg_data;
				CFG_QUERY_CLASS:  query_class_q  <= cfg_data;
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			store_mem[wr.addr[ADDR_W-1:0]] <= name_char;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cmd.valid && (cmd.src == SRC_CHAR)) begin
			char_s1 <= store_mem[cmd.idx[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s1  <= cmd.src;
			idx_s1  <= cmd.idx;
			len_s1  <= cmd.len;
			last_s1 <= cmd.last;
			end_s1  <= cmd.msg_end;
			ovf_s1  <= cmd.ovf;
		end
	end

	always_comb begin
		case (idx_s1)
			6'd0:    hdr_byte = query_id_q[15:8];
			6'd1:    hdr_byte = query_id_q[7:0];
			6'd2:    hdr_byte = header_flags_q[15:8];
			6'd3:    hdr_byte = header_flags_q[7:0];
			6'd5:    hdr_byte = 8'd1;
			default: hdr_byte = 8'd0;
		endcase
		case (idx_s1)
			6'd1:    trl_byte = query_type_q[15:8];
			6'd2:    trl_byte = query_type_q[7:0];
			6'd3:    trl_byte = query_class_q[15:8];
			6'd4:    trl_byte = query_class_q[7:0];
			default: trl_byte = 8'd0;
		endcase
		case (src_s1)
			SRC_HDR:  byte_s1 = hdr_byte;
			SRC_LEN:  byte_s1 = {{(8 - LEN_W){1'b0}}, len_s1};
			SRC_CHAR: byte_s1 = char_s1;
			SRC_TRL:  byte_s1 = trl_byte;
			default:  byte_s1 = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			have_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= cmd.valid;
			out_v_q <= 1'b0;
			if (v_s1) begin
				if (hold_first) begin
					have_q <= 1'b1;
				end else begin
					have_q  <= 1'b0;
					out_v_q <= 1'b1;
				end
			end
		end
	end

	// pack bytes in pairs; only the last byte of an item may go out alone
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			if (hold_first) begin
				first_q <= byte_s1;
			end else begin
				if (have_q) begin
					byte_first_q  <= first_q;
					byte_second_q <= byte_s1;
					byte_count_q  <= COUNT_TWO;
				end else begin
					byte_first_q  <= byte_s1;
					byte_second_q <= 8'd0;
					byte_count_q  <= COUNT_ONE;
				end
				run_end_q     <= last_s1;
				message_end_q <= end_s1;
				overflow_q    <= end_s1 && ovf_s1;
			end
		end
	end

	assign msg_valid      = out_v_q;
	assign byte_first     = byte_first_q;
	assign byte_second    = byte_second_q;
	assign byte_count     = byte_count_q;
	assign run_end        = run_end_q;
	assign message_end    = message_end_q;
	assign label_overflow = overflow_q;

endmodule

// ===== rtl/core/dns_query_packet_builder.sv =====
// DNS query builder: feed the domain name one character per beat (46 separates
// labels, final_char marks the last one) and take the query message back as
// beats of one or two bytes, most significant byte first. The first character
// of a message also sends the 12-byte header; a separator sends the buffered
// label as a length byte plus its characters; the final character closes the
// name with a zero byte, the query type and class. Characters past MAX_LABEL
// in a label are dropped and reported by label_overflow on the message_end
// beat. A character that only goes into the label buffer leaves name_stall low;
// any other item raises name_stall while the controller issues each message
// byte it sends (12 for the header, 1 + n for a label of n characters, 1 for
// an empty final label, 5 for the closing bytes), since the datapath produces
// one byte a cycle, unless msg_stall holds it, through the single read port of
// the label buffer. The label buffer has no reset and needs no clearing pass.
// The register channel is always ready; write registers only while no item is
// in flight.
`include "dns_query_packet_builder_macros.svh"

module dns_query_packet_builder
	import dqb_pkg::*;
#(
	parameter int MAX_LABEL = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 name_valid,
	output logic                 name_stall,
	input  logic [7:0]           name_char,
	input  logic                 final_char,
	output logic                 msg_valid,
	input  logic                 msg_stall,
	output logic [7:0]           byte_first,
	output logic [7:0]           byte_second,
	output logic [1:0]           byte_count,
	output logic                 run_end,
	output logic                 message_end,
	output logic                 label_overflow
);

	byte_cmd_t  cmd;
	store_wr_t  wr;
	dp_status_t status;

	dqb_ctrl #(
		.MAX_LABEL (MAX_LABEL)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.name_valid (name_valid),
		.name_stall (name_stall),
		.name_char  (name_char),
		.final_char (final_char),
		.status     (status),
		.cmd        (cmd),
		.wr         (wr)
	);

	dqb_datapath #(
		.MAX_LABEL (MAX_LABEL)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.name_char      (name_char),
		.cmd            (cmd),
		.wr             (wr),
		.status         (status),
		.msg_valid      (msg_valid),
		.msg_stall      (msg_stall),
		.byte_first     (byte_first),
		.byte_second    (byte_second),
		.byte_count     (byte_count),
		.run_end        (run_end),
		.message_end    (message_end),
		.label_overflow (label_overflow)
	);

	`DQB_ASSERT_NOW(a_end_closes_run, msg_valid && message_end, run_end, "end without run end")
	`DQB_ASSERT_NOW(a_single_is_last, msg_valid && (byte_count == COUNT_ONE), run_end, "lone byte")
	`DQB_ASSERT_NOW(a_ovf_on_end, msg_valid && label_overflow, message_end, "overflow off end")
	`DQB_ASSERT_NOW(a_store_on_accept, wr.en, name_valid && !name_stall, "store without beat")
	`DQB_ASSERT_NEXT(a_final_busy, name_valid && !name_stall && final_char, name_stall, "no close")

endmodule
